// ----- design/htt_pkg.sv -----
// Shared types, character codes, phase and token codes for the HTTP header tokenizer.
`default_nettype none
package htt_pkg;

   // Upper bound on the header length limit; the step checks each byte against it as well as the register
   localparam int MaxLen = 4096;

   localparam int CntW  = 13;
   localparam int LineW = 12;
   localparam int PhW   = 4;
   localparam int KindW = 3;

   localparam logic [CntW-1:0]  CntMax  = '1;
   localparam logic [LineW-1:0] LineMax = '1;
   localparam logic [CntW-1:0]  MaxLenReset = 13'd4096;

   // Characters that steer the parse
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   // Parse phases
   localparam logic [PhW-1:0] PH_IDLE       = 4'd0;
   localparam logic [PhW-1:0] PH_METHOD     = 4'd1;
   localparam logic [PhW-1:0] PH_TARGET     = 4'd2;
   localparam logic [PhW-1:0] PH_VERSION    = 4'd3;
   localparam logic [PhW-1:0] PH_LINE_CR    = 4'd4;
   localparam logic [PhW-1:0] PH_LINE_START = 4'd5;
   localparam logic [PhW-1:0] PH_NAME       = 4'd6;
   localparam logic [PhW-1:0] PH_SKIP       = 4'd7;
   localparam logic [PhW-1:0] PH_VALUE      = 4'd8;
   localparam logic [PhW-1:0] PH_END_CR     = 4'd9;

   // Token kinds
   localparam logic [KindW-1:0] K_TARGET     = 3'd0;
   localparam logic [KindW-1:0] K_VERSION    = 3'd1;
   localparam logic [KindW-1:0] K_NAME       = 3'd2;
   localparam logic [KindW-1:0] K_VALUE      = 3'd3;
   localparam logic [KindW-1:0] K_LINE_END   = 3'd4;
   localparam logic [KindW-1:0] K_HEADER_END = 3'd5;
   localparam logic [KindW-1:0] K_ERROR      = 3'd6;

   typedef struct packed {
      logic [PhW-1:0]   phase;
      logic [LineW-1:0] line_cnt;
      logic [CntW-1:0]  byte_cnt;
   } htt_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_request;
   } htt_item_type;

   typedef struct packed {
      logic [KindW-1:0] token_kind;
      logic [7:0]       token_byte;
      logic [LineW-1:0] line_index;
   } htt_token_type;

endpackage
`default_nettype wire

// ----- design/htt_channels.sv -----
// Valid/ready channel interfaces for header bytes in and tokens out.
`default_nettype none
interface htt_req_if;
   import htt_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_request;
   modport source (output valid, output data_byte, output start_of_request, input ready);
   modport sink   (input valid, input data_byte, input start_of_request, output ready);
endinterface

interface htt_rsp_if;
   import htt_pkg::*;
   logic             valid;
   logic             ready;
   logic [KindW-1:0] token_kind;
   logic [7:0]       token_byte;
   logic [LineW-1:0] line_index;
   modport source (output valid, output token_kind, output token_byte, output line_index,
                   input ready);
   modport sink   (input valid, input token_kind, input token_byte, input line_index,
                   output ready);
endinterface
`default_nettype wire

// ----- design/htt_step.sv -----
// Next-state and token logic for one header byte.
`default_nettype none
module htt_step #(
   parameter int MaxLen = htt_pkg::MaxLen
) (
   input  htt_pkg::htt_state_type      state,
   input  htt_pkg::htt_item_type       item,
   input  logic [htt_pkg::CntW-1:0]    max_len,
   output htt_pkg::htt_state_type      state_next,
   output logic                        tok_valid,
   output htt_pkg::htt_token_type      tok
);
   import htt_pkg::*;

   htt_state_type    work;
   logic [7:0]       b;
   logic             overrun;
   logic             fail;

   always_comb begin
      b          = item.data_byte;
      work       = state;
      fail       = 1'b0;
      overrun    = 1'b0;
      tok_valid  = 1'b0;
      tok        = '0;

      // Restart on the start mark whatever the phase
      if (item.start_of_request) begin
         work.phase    = PH_METHOD;
         work.line_cnt = '0;
         work.byte_cnt = '0;
      end
      tok.line_index = work.line_cnt;

      if (work.phase != PH_IDLE) begin
         // Count the byte, saturating, and check the length limit
         if (work.byte_cnt != CntMax) begin
            work.byte_cnt = work.byte_cnt + 1'b1;
         end
         overrun = (work.byte_cnt > max_len) || (32'(work.byte_cnt) > 32'(MaxLen));
         if (overrun) begin
            fail = 1'b1;
         end else begin
            unique case (work.phase)
               PH_METHOD: begin
                  if (b == CH_CR || b == CH_LF) fail = 1'b1;
                  else if (b == CH_SPACE) work.phase = PH_TARGET;
               end
               PH_TARGET: begin
                  if (b == CH_CR || b == CH_LF) fail = 1'b1;
                  else if (b == CH_SPACE) work.phase = PH_VERSION;
                  else begin
                     tok_valid      = 1'b1;
                     tok.token_kind = K_TARGET;
                     tok.token_byte = b;
                  end
               end
               PH_VERSION: begin
                  if (b == CH_LF) fail = 1'b1;
                  else if (b == CH_CR) work.phase = PH_LINE_CR;
                  else begin
                     tok_valid      = 1'b1;
                     tok.token_kind = K_VERSION;
                     tok.token_byte = b;
                  end
               end
               PH_LINE_CR: begin
                  if (b != CH_LF) fail = 1'b1;
                  else begin
                     work.phase     = PH_LINE_START;
                     tok_valid      = 1'b1;
                     tok.token_kind = K_LINE_END;
                     if (work.line_cnt != LineMax) begin
                        work.line_cnt = work.line_cnt + 1'b1;
                     end
                  end
               end
               PH_LINE_START: begin
                  if (b == CH_LF) fail = 1'b1;
                  else if (b == CH_CR) work.phase = PH_END_CR;
                  else if (b == CH_COLON) work.phase = PH_SKIP;
                  else begin
                     work.phase     = PH_NAME;
                     tok_valid      = 1'b1;
                     tok.token_kind = K_NAME;
                     tok.token_byte = b;
                  end
               end
               PH_NAME: begin
                  if (b == CH_CR || b == CH_LF) fail = 1'b1;
                  else if (b == CH_COLON) work.phase = PH_SKIP;
                  else begin
                     tok_valid      = 1'b1;
                     tok.token_kind = K_NAME;
                     tok.token_byte = b;
                  end
               end
               PH_SKIP: begin
                  if (b == CH_LF) fail = 1'b1;
                  else if (b == CH_CR) work.phase = PH_LINE_CR;
                  else work.phase = PH_VALUE;
               end
               PH_VALUE: begin
                  if (b == CH_LF) fail = 1'b1;
                  else if (b == CH_CR) work.phase = PH_LINE_CR;
                  else begin
                     tok_valid      = 1'b1;
                     tok.token_kind = K_VALUE;
                     tok.token_byte = b;
                  end
               end
               PH_END_CR: begin
                  if (b != CH_LF) fail = 1'b1;
                  else begin
                     work.phase     = PH_IDLE;
                     tok_valid      = 1'b1;
                     tok.token_kind = K_HEADER_END;
                  end
               end
               default: begin
                  work.phase = PH_IDLE;
               end
            endcase
         end

         // Drop to idle and report the error on the current line
         if (fail) begin
            work.phase     = PH_IDLE;
            tok_valid      = 1'b1;
            tok.token_kind = K_ERROR;
            tok.token_byte = '0;
            tok.line_index = work.line_cnt;
         end
      end

      state_next = work;
   end

endmodule
`default_nettype wire

// ----- design/http_header_tokenizer.sv -----
// Top level of the byte-serial HTTP request header tokenizer.
//
//  channel  | direction | payload                                 | transfer when
//  ---------+-----------+-----------------------------------------+-------------------
//  req      | in        | data_byte, start_of_request             | valid && ready
//  rsp      | out       | token_kind, token_byte, line_index      | valid && ready
//  csr      | in        | csr_write_data (max_header_len)         | csr_write_enable
//
// One byte per cycle sustained while tokens are taken: a byte is held in the input
// register, the parse step runs from there into the token register, which drives
// rsp. Bytes that produce no token are consumed without output.
// Reset (synchronous) empties both registers, puts the parser in idle and sets the
// length limit to 4096. A stalled token holds the token register and, behind it, the
// input register; req_ready drops only while both are full.
`default_nettype none
module http_header_tokenizer #(
   parameter int MaxLen = htt_pkg::MaxLen
) (
   input  logic                     clock,
   input  logic                     reset,
   htt_req_if.sink                  req,
   htt_rsp_if.source                rsp,
   input  logic                     csr_write_enable,
   input  logic [htt_pkg::CntW-1:0] csr_write_data
);
   import htt_pkg::*;

   logic                 in_valid_ff,  in_valid_in;
   htt_item_type         in_item_ff,   in_item_in;
   htt_state_type        state_ff,     state_in;
   logic                 out_valid_ff, out_valid_in;
   htt_token_type        out_tok_ff,   out_tok_in;
   logic [CntW-1:0]      max_len_ff,   max_len_in;

   htt_state_type        step_state;
   logic                 step_valid;
   htt_token_type        step_tok;
   logic                 advance;
   logic                 in_take;

   htt_step #(
      .MaxLen     (MaxLen)
   ) u_step (
      .state      (state_ff),
      .item       (in_item_ff),
      .max_len    (max_len_ff),
      .state_next (step_state),
      .tok_valid  (step_valid),
      .tok        (step_tok)
   );

   // Advance the held byte when the token register is free
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || advance;
   assign in_take   = req.valid && req.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_tok_in   = out_tok_ff;
      max_len_in   = max_len_ff;

      // Retire a delivered token
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      // Process the held byte
      if (in_valid_ff && advance) begin
         state_in     = step_state;
         out_valid_in = step_valid;
         if (step_valid) begin
            out_tok_in = step_tok;
         end
         in_valid_in = 1'b0;
      end
      // Capture a new byte
      if (in_take) begin
         in_valid_in                 = 1'b1;
         in_item_in.data_byte        = req.data_byte;
         in_item_in.start_of_request = req.start_of_request;
      end
      // Update the length limit
      if (csr_write_enable) begin
         max_len_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_IDLE, line_cnt: '0, byte_cnt: '0};
         max_len_ff   <= MaxLenReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         max_len_ff   <= max_len_in;
      end
      in_item_ff <= in_item_in;
      out_tok_ff <= out_tok_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.token_kind = out_tok_ff.token_kind;
   assign rsp.token_byte = out_tok_ff.token_byte;
   assign rsp.line_index = out_tok_ff.line_index;

endmodule
`default_nettype wire

// ----- bench/tb_http_header_tokenizer.sv -----
// Self-checking testbench for the HTTP header tokenizer: byte stimulus, token prediction.
module tb_http_header_tokenizer;
   import htt_pkg::*;

   localparam int WatchdogLimit = 4000;
   localparam int HoldCycles    = 300;
   localparam int DrainCycles   = 8;

   localparam logic [7:0] SEPARATORS [4] = '{CH_CR, CH_LF, CH_COLON, CH_SPACE};

   // Byte classes for random header content
   typedef enum {SEG_TOKEN, SEG_NAME, SEG_TEXT} seg_kind_type;

   // Tracks parser state and holds the tokens still owed by the block
   class token_tracker;
      logic [CntW-1:0]  len_limit;
      logic [PhW-1:0]   phase;
      logic [LineW-1:0] line_cnt;
      logic [CntW-1:0]  byte_cnt;
      htt_token_type    pending_tokens[$];
      int               error_count;

      function new();
         len_limit   = MaxLenReset;
         phase       = PH_IDLE;
         line_cnt    = '0;
         byte_cnt    = '0;
         error_count = 0;
      endfunction

      function void set_limit(logic [CntW-1:0] value);
         len_limit = value;
      endfunction

      function int pending();
         return pending_tokens.size();
      endfunction

      // Advance the parse by one accepted byte and queue the token it yields
      function void note_byte(htt_item_type item);
         logic [7:0]      b;
         logic [CntW-1:0] lim;
         htt_token_type   tok;
         bit              has_token;
         bit              malformed;
         b = item.data_byte;
         has_token = 1'b0;
         malformed = 1'b0;
         if (item.start_of_request) begin
            phase    = PH_METHOD;
            line_cnt = '0;
            byte_cnt = '0;
         end
         if (phase == PH_IDLE)
            return;
         tok.token_kind = K_ERROR;
         tok.token_byte = 8'h00;
         tok.line_index = line_cnt;
         if (byte_cnt != CntMax)
            byte_cnt++;
         lim = (len_limit > MaxLen) ? CntW'(MaxLen) : len_limit;
         if (byte_cnt > lim) begin
            malformed = 1'b1;
         end else begin
            case (phase)
               PH_METHOD: begin
                  if (b == CH_CR || b == CH_LF) malformed = 1'b1;
                  else if (b == CH_SPACE) phase = PH_TARGET;
               end
               PH_TARGET: begin
                  if (b == CH_CR || b == CH_LF) malformed = 1'b1;
                  else if (b == CH_SPACE) phase = PH_VERSION;
                  else begin
                     has_token = 1'b1;
                     tok.token_kind = K_TARGET;
                     tok.token_byte = b;
                  end
               end
               PH_VERSION: begin
                  if (b == CH_LF) malformed = 1'b1;
                  else if (b == CH_CR) phase = PH_LINE_CR;
                  else begin
                     has_token = 1'b1;
                     tok.token_kind = K_VERSION;
                     tok.token_byte = b;
                  end
               end
               PH_LINE_CR: begin
                  if (b != CH_LF) malformed = 1'b1;
                  else begin
                     phase = PH_LINE_START;
                     has_token = 1'b1;
                     tok.token_kind = K_LINE_END;
                     if (line_cnt != LineMax)
                        line_cnt++;
                  end
               end
               PH_LINE_START: begin
                  if (b == CH_LF) malformed = 1'b1;
                  else if (b == CH_CR) phase = PH_END_CR;
                  else if (b == CH_COLON) phase = PH_SKIP;
                  else begin
                     phase = PH_NAME;
                     has_token = 1'b1;
                     tok.token_kind = K_NAME;
                     tok.token_byte = b;
                  end
               end
               PH_NAME: begin
                  if (b == CH_CR || b == CH_LF) malformed = 1'b1;
                  else if (b == CH_COLON) phase = PH_SKIP;
                  else begin
                     has_token = 1'b1;
                     tok.token_kind = K_NAME;
                     tok.token_byte = b;
                  end
               end
               PH_SKIP: begin
                  if (b == CH_LF) malformed = 1'b1;
                  else phase = (b == CH_CR) ? PH_LINE_CR : PH_VALUE;
               end
               PH_VALUE: begin
                  if (b == CH_LF) malformed = 1'b1;
                  else if (b == CH_CR) phase = PH_LINE_CR;
                  else begin
                     has_token = 1'b1;
                     tok.token_kind = K_VALUE;
                     tok.token_byte = b;
                  end
               end
               PH_END_CR: begin
                  if (b != CH_LF) malformed = 1'b1;
                  else begin
                     phase = PH_IDLE;
                     has_token = 1'b1;
                     tok.token_kind = K_HEADER_END;
                  end
               end
               default: phase = PH_IDLE;
            endcase
         end
         // Drop to idle and report the error on the current line
         if (malformed) begin
            phase = PH_IDLE;
            has_token = 1'b1;
            tok.token_kind = K_ERROR;
            tok.token_byte = 8'h00;
            tok.line_index = line_cnt;
         end
         if (has_token)
            pending_tokens.push_back(tok);
      endfunction

      // Compare one transferred token with the oldest one owed
      function void check_token(htt_token_type got);
         htt_token_type want;
         if (pending_tokens.size() == 0) begin
            $display("%0t: unexpected token kind %0d byte %02h line %0d", $time,
                     got.token_kind, got.token_byte, got.line_index);
            error_count++;
            return;
         end
         want = pending_tokens.pop_front();
         if (got.token_kind !== want.token_kind || got.token_byte !== want.token_byte ||
             got.line_index !== want.line_index) begin
            $display("%0t: expected kind %0d byte %02h line %0d, got kind %0d byte %02h line %0d",
                     $time, want.token_kind, want.token_byte, want.line_index,
                     got.token_kind, got.token_byte, got.line_index);
            error_count++;
         end
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset;
   logic            csr_write_enable;
   logic [CntW-1:0] csr_write_data;

   htt_req_if req_bus ();
   htt_rsp_if rsp_bus ();

   token_tracker tokens = new();

   int           send_idle_pct = 0;
   int           stall_pct     = 0;
   bit           hold_request  = 1'b0;
   int           hold_left     = 0;
   int           items_sent    = 0;
   int           quiet_cycles  = 0;
   htt_item_type req_bytes[$];

   http_header_tokenizer dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Pick a random byte that is legal inside the given header part
   function automatic logic [7:0] pick_byte(seg_kind_type seg);
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == CH_CR || b == CH_LF || (seg == SEG_TOKEN && b == CH_SPACE) ||
             (seg == SEG_NAME && b == CH_COLON));
      return b;
   endfunction

   function automatic void add_byte(logic [7:0] b);
      htt_item_type item;
      item.data_byte        = b;
      item.start_of_request = (req_bytes.size() == 0);
      req_bytes.push_back(item);
   endfunction

   // Build one well-formed request with random content, then sometimes corrupt it
   function automatic void build_request();
      int n;
      req_bytes.delete();
      repeat ($urandom_range(0, 3)) add_byte(pick_byte(SEG_TOKEN));
      add_byte(CH_SPACE);
      repeat ($urandom_range(0, 5)) add_byte(pick_byte(SEG_TOKEN));
      add_byte(CH_SPACE);
      repeat ($urandom_range(0, 4)) add_byte(pick_byte(SEG_TEXT));
      add_byte(CH_CR);
      add_byte(CH_LF);
      repeat ($urandom_range(0, 3)) begin
         repeat ($urandom_range(0, 4)) add_byte(pick_byte(SEG_NAME));
         add_byte(CH_COLON);
         if ($urandom_range(0, 99) < 15) begin
            add_byte(CH_CR);
         end else begin
            add_byte(($urandom_range(0, 1) == 0) ? CH_SPACE : pick_byte(SEG_TEXT));
            repeat ($urandom_range(0, 5)) add_byte(pick_byte(SEG_TEXT));
            add_byte(CH_CR);
         end
         add_byte(CH_LF);
      end
      add_byte(CH_CR);
      add_byte(CH_LF);
      if ($urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, req_bytes.size() - 1);
         case ($urandom_range(0, 3))
            0: req_bytes[n].data_byte = SEPARATORS[$urandom_range(0, 3)];
            1: req_bytes[n].data_byte = 8'($urandom_range(0, 255));
            2: while (req_bytes.size() > n) void'(req_bytes.pop_back());
            default: req_bytes[n].start_of_request = 1'b1;
         endcase
      end
   endfunction

   // Offer one byte after a random gap and hold it until the transfer
   task automatic send_item(htt_item_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.data_byte        <= item.data_byte;
      req_bus.start_of_request <= item.start_of_request;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      tokens.note_byte(item);
   endtask

   task automatic send_byte(logic [7:0] b, logic sor);
      htt_item_type item;
      item.data_byte        = b;
      item.start_of_request = sor;
      send_item(item);
   endtask

   // Stop offering bytes until every owed token has arrived, then let the pipe settle
   task automatic wait_for_tokens();
      req_bus.valid <= 1'b0;
      while (tokens.pending() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_limit(logic [CntW-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tokens.set_limit(value);
   endtask

   task automatic send_request();
      htt_item_type stray;
      build_request();
      // Occasionally slip in a byte with no start mark
      if ($urandom_range(0, 9) == 0) begin
         stray.data_byte        = 8'($urandom_range(0, 255));
         stray.start_of_request = 1'b0;
         send_item(stray);
      end
      foreach (req_bytes[i]) send_item(req_bytes[i]);
      items_sent += req_bytes.size();
      if ($urandom_range(0, 19) == 0)
         wait_for_tokens();
   endtask

   task automatic run_phase(int n_items, int idle_pct, int stall);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      items_sent    = 0;
      while (items_sent < n_items) send_request();
   endtask

   // Directed header: empty name, empty value, extreme bytes, then error cases
   task automatic run_directed();
      logic [7:0] good_hdr [19] = '{8'h47, CH_SPACE, 8'h00, 8'hFF, CH_SPACE, 8'h7F,
                                    CH_CR, CH_LF, CH_COLON, CH_CR, CH_LF, 8'h80,
                                    CH_COLON, CH_SPACE, 8'h01, CH_CR, CH_LF, CH_CR, CH_LF};
      logic [7:0] bare_cr [4] = '{CH_SPACE, CH_SPACE, CH_CR, 8'h7A};
      send_idle_pct = 0;
      stall_pct     = 0;
      foreach (good_hdr[i]) send_byte(good_hdr[i], i == 0);
      // Idle after header end: ignored
      send_byte(8'hFE, 1'b0);
      // LF and CR inside the method
      send_byte(CH_LF, 1'b1);
      send_byte(CH_CR, 1'b1);
      // CR not followed by LF
      foreach (bare_cr[i]) send_byte(bare_cr[i], i == 0);
      send_byte(CH_COLON, 1'b0);
   endtask

   // Receiver: random stalls, plus a long hold when asked
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HoldCycles;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Check every token transfer
   initial begin
      htt_token_type got;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.token_kind = rsp_bus.token_kind;
            got.token_byte = rsp_bus.token_byte;
            got.line_index = rsp_bus.line_index;
            tokens.check_token(got);
         end
      end
   end

   // Watchdog: end the run after too long without any transfer
   initial begin
      forever begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Main sequence
   initial begin
      reset                    <= 1'b1;
      req_bus.valid            <= 1'b0;
      req_bus.data_byte        <= 8'h00;
      req_bus.start_of_request <= 1'b0;
      csr_write_enable         <= 1'b0;
      csr_write_data           <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_phase(100, 0, 0);
      wait_for_tokens();

      write_limit(13'd16);
      run_phase(110, 81, 0);
      wait_for_tokens();

      write_limit(13'd4096);
      run_phase(110, 0, 81);
      wait_for_tokens();

      write_limit(13'($urandom_range(17, 200)));
      run_phase(150, 13, 13);
      wait_for_tokens();

      // Hold off the receiver while bytes keep coming
      write_limit(13'd40);
      hold_request = 1'b1;
      run_phase(150, 0, 0);
      wait_for_tokens();

      if (tokens.error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
